@@ sv/linear_interp_pcm_resampler_macros.svh @@
// Assertion macros for the linear interpolating PCM resampler.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef LINEAR_INTERP_PCM_RESAMPLER_MACROS_SVH
`define LINEAR_INTERP_PCM_RESAMPLER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LIPR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lipr: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LIPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lipr: next-cycle check failed");

`endif

@@ sv/lipr_pkg.sv @@
// Shared types, constants and helper functions of the PCM resampler.
// Used by the interfaces, the controller, the datapath and the top level.
package lipr_pkg;

  localparam int SampleW  = 16;
  localparam int RateW    = 16;
  localparam int RemW     = RateW + 1;
  localparam int LegCap   = 12;
  localparam int LegW     = 4;
  localparam int DivSteps = 16;
  localparam int DivCntW  = 4;
  localparam int NumW     = 2 * RateW + 2;
  localparam int MagW     = 2 * RateW;
  localparam int IdxW     = 2;
  localparam int Lanes    = 2;

  localparam logic [IdxW-1:0] RegSourceRate = 2'd0;
  localparam logic [IdxW-1:0] RegTargetRate = 2'd1;
  localparam logic [IdxW-1:0] RegEightBit   = 2'd2;
  localparam logic [IdxW-1:0] RegStereo     = 2'd3;

  localparam logic [RateW-1:0] SourceRateReset = 16'd22050;
  localparam logic [RateW-1:0] TargetRateReset = 16'd44100;

  localparam logic signed [SampleW:0] SampleMax = 17'sd32767;
  localparam logic signed [SampleW:0] SampleMin = -17'sd32768;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INTERP_TEST,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_ADV,
    ST_EMIT_I,
    ST_HOLD_TEST,
    ST_EMIT_H,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic ready;
    logic load;
    logic interp_close;
    logic mul;
    logic sum;
    logic div_step;
    logic advance;
    logic emit;
    logic hold;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic have_prev;
    logic fin;
    logic interp_more;
    logic hold_more;
    logic div_last;
    logic out_free;
  } status_t;

  // An 8-bit sample is unsigned in the low byte; (s - 128) * 256 is the
  // byte with its top bit inverted, placed in the high byte.
  function automatic logic signed [SampleW-1:0] widen(input logic [SampleW-1:0] raw,
                                                      input logic eight_bit);
    logic signed [SampleW-1:0] w;
    if (eight_bit) begin
      w = $signed({~raw[7], raw[6:0], 8'h00});
    end else begin
      w = $signed(raw);
    end
    return w;
  endfunction

endpackage

@@ sv/lipr_if.sv @@
// Valid/ready channel interfaces for source frames and resampled frames.
// Depends on lipr_pkg for the sample width.
interface lipr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [lipr_pkg::SampleW-1:0] left_sample;
  logic signed [lipr_pkg::SampleW-1:0] right_sample;
  logic                                final_frame;

  modport source(output valid, left_sample, right_sample, final_frame, input ready);
  modport sink(input valid, left_sample, right_sample, final_frame, output ready);
endinterface

interface lipr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lipr_pkg::SampleW-1:0] out_left;
  logic signed [lipr_pkg::SampleW-1:0] out_right;
  logic                                run_end;
  logic                                stream_end;

  modport source(output valid, out_left, out_right, run_end, stream_end, input ready);
  modport sink(input valid, out_left, out_right, run_end, stream_end, output ready);
endinterface

@@ sv/linear_interp_pcm_resampler.sv @@
// Channel    | Dir | Transfer when       | Carries
// src        | in  | src.valid&src.ready | left_sample, right_sample, final_frame
// dst        | out | dst.valid&dst.ready | out_left, out_right, run_end, stream_end
// wr_*       | in  | wr_en               | wr_index, wr_data (rate and mode registers)
//
// One source frame at a time. Each interpolated result passes through the
// sixteen-step restoring divider that both channels share in lockstep; a
// held result skips it, and each frame also passes its test and update steps.
// Reset is synchronous and returns the rates and modes to their defaults and
// clears the stream state. A stalled output holds the machine at its emit step.
// Top level of the PCM resampler: controller, datapath and checks.
// Depends on lipr_pkg, lipr_if.sv, lipr_ctrl, lipr_datapath and the macro header.
`include "linear_interp_pcm_resampler_macros.svh"

module linear_interp_pcm_resampler (
  input  logic                       clk,
  input  logic                       rst,
  lipr_in_if.sink                    src,
  lipr_out_if.source                 dst,
  input  logic                       wr_en,
  input  logic [lipr_pkg::IdxW-1:0]  wr_index,
  input  logic [lipr_pkg::RateW-1:0] wr_data
);

  lipr_pkg::cmd_t    cmd;
  lipr_pkg::status_t sts;

  lipr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (src.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  lipr_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .src      (src),
    .dst      (dst),
    .cmd      (cmd),
    .sts      (sts)
  );

  // A result may only be loaded when the output register is free to take it.
  `LIPR_ASSERT_NOW(a_emit_room, cmd.emit, sts.out_free)
  // A frame is worked on alone: no new transfer right after one is taken.
  `LIPR_ASSERT_NEXT(a_one_frame, src.valid && src.ready, !src.ready)
  // The end of a stream is always the end of its frame's run.
  `LIPR_ASSERT_NOW(a_stream_run, dst.valid && dst.stream_end, dst.run_end)

endmodule

@@ sv/lipr_ctrl.sv @@
// Sequencing state machine of the PCM resampler.
// Depends on lipr_pkg for the state, command and status types.
module lipr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  lipr_pkg::status_t sts,
  output lipr_pkg::cmd_t    cmd
);

  lipr_pkg::state_t state;
  lipr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lipr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      lipr_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = lipr_pkg::ST_INTERP_TEST;
        end
      end
      lipr_pkg::ST_INTERP_TEST: begin
        // Without a previous frame there is nothing to interpolate from.
        if (!sts.have_prev) begin
          state_next = sts.fin ? lipr_pkg::ST_HOLD_TEST : lipr_pkg::ST_FINISH;
        end else if (sts.interp_more) begin
          state_next = lipr_pkg::ST_MUL;
        end else begin
          cmd.interp_close = 1'b1;
          state_next = sts.fin ? lipr_pkg::ST_HOLD_TEST : lipr_pkg::ST_FINISH;
        end
      end
      lipr_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = lipr_pkg::ST_SUM;
      end
      lipr_pkg::ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = lipr_pkg::ST_DIV;
      end
      lipr_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = lipr_pkg::ST_ADV;
        end
      end
      lipr_pkg::ST_ADV: begin
        cmd.advance = 1'b1;
        state_next  = lipr_pkg::ST_EMIT_I;
      end
      lipr_pkg::ST_EMIT_I: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = lipr_pkg::ST_INTERP_TEST;
        end
      end
      lipr_pkg::ST_HOLD_TEST: begin
        if (sts.hold_more) begin
          cmd.advance = 1'b1;
          state_next  = lipr_pkg::ST_EMIT_H;
        end else begin
          state_next = lipr_pkg::ST_FINISH;
        end
      end
      lipr_pkg::ST_EMIT_H: begin
        cmd.hold = 1'b1;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = lipr_pkg::ST_HOLD_TEST;
        end
      end
      lipr_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = lipr_pkg::ST_IDLE;
      end
      default: begin
        state_next = lipr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/lipr_datapath.sv @@
// Datapath of the PCM resampler: rate registers, stream state, products,
// a two-lane restoring divider and the output register.
// Depends on lipr_pkg and on the channel interfaces in lipr_if.sv.
module lipr_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [lipr_pkg::IdxW-1:0]     wr_index,
  input  logic [lipr_pkg::RateW-1:0]    wr_data,
  lipr_in_if.sink                       src,
  lipr_out_if.source                    dst,
  input  lipr_pkg::cmd_t                cmd,
  output lipr_pkg::status_t             sts
);

  // Configuration registers.
  logic [lipr_pkg::RateW-1:0] source_rate;
  logic [lipr_pkg::RateW-1:0] target_rate;
  logic                       eight_bit_mode;
  logic                       stereo_mode;

  // Stream state kept between frames.
  logic                              have_prev;
  logic signed [lipr_pkg::SampleW-1:0] prev_l;
  logic signed [lipr_pkg::SampleW-1:0] prev_r;
  logic [lipr_pkg::RateW-1:0]        phase;

  // Working registers of the frame in progress.
  logic signed [lipr_pkg::SampleW-1:0] cur_l;
  logic signed [lipr_pkg::SampleW-1:0] cur_r;
  logic                              fin;
  logic [lipr_pkg::RemW-1:0]         rem_w;
  logic [lipr_pkg::LegW-1:0]         leg;

  // Per-lane arithmetic.
  logic signed [lipr_pkg::NumW-1:0]    prod_a [lipr_pkg::Lanes];
  logic signed [lipr_pkg::NumW-1:0]    prod_d [lipr_pkg::Lanes];
  logic                                neg    [lipr_pkg::Lanes];
  logic [lipr_pkg::RateW-1:0]          div_rem [lipr_pkg::Lanes];
  logic [lipr_pkg::RateW-1:0]          div_low [lipr_pkg::Lanes];
  logic [lipr_pkg::DivCntW-1:0]        div_cnt;

  logic signed [lipr_pkg::SampleW:0]   a17   [lipr_pkg::Lanes];
  logic signed [lipr_pkg::SampleW:0]   d17   [lipr_pkg::Lanes];
  logic signed [lipr_pkg::NumW-1:0]    num   [lipr_pkg::Lanes];
  logic [lipr_pkg::NumW-1:0]           mag   [lipr_pkg::Lanes];
  logic [lipr_pkg::RemW-1:0]           trial [lipr_pkg::Lanes];
  logic                                ge    [lipr_pkg::Lanes];
  logic signed [lipr_pkg::SampleW:0]   q_s   [lipr_pkg::Lanes];
  logic signed [lipr_pkg::SampleW-1:0] q_sat [lipr_pkg::Lanes];
  logic signed [lipr_pkg::RateW:0]     t17;
  logic signed [lipr_pkg::RateW:0]     r17;

  // Phase bookkeeping.
  logic [lipr_pkg::RemW:0]   rem_diff;
  logic                      rem_lt_t;
  logic [lipr_pkg::RemW-1:0] close_rem;
  logic [lipr_pkg::RemW:0]   hold_sum;
  logic [lipr_pkg::RemW:0]   close_sum;
  logic                      leg_open;
  logic                      after_close_ok;
  logic                      last;

  // Output register.
  logic                              out_valid;
  logic signed [lipr_pkg::SampleW-1:0] out_l;
  logic signed [lipr_pkg::SampleW-1:0] out_r;
  logic                              out_run_end;
  logic                              out_stream_end;
  logic signed [lipr_pkg::SampleW-1:0] res_l;
  logic signed [lipr_pkg::SampleW-1:0] res_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_rate    <= lipr_pkg::SourceRateReset;
      target_rate    <= lipr_pkg::TargetRateReset;
      eight_bit_mode <= 1'b0;
      stereo_mode    <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        lipr_pkg::RegSourceRate: source_rate    <= wr_data;
        lipr_pkg::RegTargetRate: target_rate    <= wr_data;
        lipr_pkg::RegEightBit:   eight_bit_mode <= wr_data[0];
        lipr_pkg::RegStereo:     stereo_mode    <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign src.ready = cmd.ready;

  always_comb begin
    rem_diff  = {1'b0, rem_w} - {2'b00, target_rate};
    rem_lt_t  = rem_diff[lipr_pkg::RemW];
    close_rem = rem_lt_t ? '0 : rem_diff[lipr_pkg::RemW-1:0];
    hold_sum  = {1'b0, rem_w} + {2'b00, source_rate};
    close_sum = {1'b0, close_rem} + {2'b00, source_rate};
    leg_open  = (leg != lipr_pkg::LegW'(lipr_pkg::LegCap));
    after_close_ok = fin && (close_sum <= {2'b00, target_rate});

    sts.have_prev   = have_prev;
    sts.fin         = fin;
    sts.interp_more = rem_lt_t && leg_open;
    sts.hold_more   = (hold_sum <= {2'b00, target_rate}) && leg_open;
    sts.div_last    = (div_cnt == lipr_pkg::DivCntW'(lipr_pkg::DivSteps - 1));
    sts.out_free    = !out_valid || dst.ready;

    // Lookahead: is another result due from this frame after the one emitted?
    if (cmd.hold) begin
      last = !sts.hold_more;
    end else begin
      last = !(sts.interp_more || after_close_ok);
    end
  end

  always_comb begin
    t17 = $signed({1'b0, target_rate});
    r17 = $signed({1'b0, rem_w[lipr_pkg::RateW-1:0]});
    a17[0] = {prev_l[lipr_pkg::SampleW-1], prev_l};
    a17[1] = {prev_r[lipr_pkg::SampleW-1], prev_r};
    d17[0] = {cur_l[lipr_pkg::SampleW-1], cur_l} - a17[0];
    d17[1] = {cur_r[lipr_pkg::SampleW-1], cur_r} - a17[1];
    for (int k = 0; k < lipr_pkg::Lanes; k++) begin
      num[k]   = prod_a[k] + prod_d[k];
      mag[k]   = num[k][lipr_pkg::NumW-1] ? $unsigned(-num[k]) : $unsigned(num[k]);
      trial[k] = {div_rem[k], div_low[k][lipr_pkg::RateW-1]};
      ge[k]    = (trial[k] >= {1'b0, target_rate});
      q_s[k]   = neg[k] ? -$signed({1'b0, div_low[k]}) : $signed({1'b0, div_low[k]});
      if (q_s[k] > lipr_pkg::SampleMax) begin
        q_sat[k] = lipr_pkg::SampleMax[lipr_pkg::SampleW-1:0];
      end else if (q_s[k] < lipr_pkg::SampleMin) begin
        q_sat[k] = lipr_pkg::SampleMin[lipr_pkg::SampleW-1:0];
      end else begin
        q_sat[k] = q_s[k][lipr_pkg::SampleW-1:0];
      end
    end
    res_l = cmd.hold ? cur_l : q_sat[0];
    res_r = cmd.hold ? cur_r : q_sat[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      prev_l    <= '0;
      prev_r    <= '0;
      phase     <= '0;
      leg       <= '0;
      div_cnt   <= '0;
    end else begin
      if (cmd.load) begin
        cur_l <= lipr_pkg::widen(src.left_sample, eight_bit_mode);
        cur_r <= stereo_mode ? lipr_pkg::widen(src.right_sample, eight_bit_mode) : '0;
        fin   <= src.final_frame;
        rem_w <= {1'b0, phase};
        leg   <= '0;
      end
      // A close subtracts target_rate; a capped leg below it drops the rest.
      if (cmd.interp_close) begin
        rem_w <= close_rem;
        leg   <= '0;
      end
      if (cmd.advance) begin
        rem_w <= rem_w + {1'b0, source_rate};
        leg   <= leg + 1'b1;
      end
      if (cmd.sum) begin
        div_cnt <= '0;
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt + 1'b1;
      end
      if (cmd.finish) begin
        if (fin) begin
          have_prev <= 1'b0;
          prev_l    <= '0;
          prev_r    <= '0;
          phase     <= '0;
        end else begin
          have_prev <= 1'b1;
          prev_l    <= cur_l;
          prev_r    <= cur_r;
          phase     <= rem_w[lipr_pkg::RateW-1:0];
        end
      end
    end
  end

  // The dividend magnitude is below target_rate * 2^16, so sixteen restoring
  // steps give the whole quotient.
  always_ff @(posedge clk) begin
    for (int k = 0; k < lipr_pkg::Lanes; k++) begin
      if (cmd.mul) begin
        prod_a[k] <= a17[k] * t17;
        prod_d[k] <= d17[k] * r17;
      end
      if (cmd.sum) begin
        neg[k]     <= num[k][lipr_pkg::NumW-1];
        div_rem[k] <= mag[k][lipr_pkg::MagW-1:lipr_pkg::RateW];
        div_low[k] <= mag[k][lipr_pkg::RateW-1:0];
      end
      if (cmd.div_step) begin
        div_rem[k] <= ge[k] ? lipr_pkg::RateW'(trial[k] - {1'b0, target_rate})
                            : trial[k][lipr_pkg::RateW-1:0];
        div_low[k] <= {div_low[k][lipr_pkg::RateW-2:0], ge[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (dst.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_l          <= res_l;
      out_r          <= stereo_mode ? res_r : '0;
      out_run_end    <= last;
      out_stream_end <= last && fin;
    end
  end

  assign dst.valid      = out_valid;
  assign dst.out_left   = out_l;
  assign dst.out_right  = out_r;
  assign dst.run_end    = out_run_end;
  assign dst.stream_end = out_stream_end;

endmodule
